[rtl/hegd_pkg.sv]
// Package for the hand enter/leave gesture detector.
// Holds zone and gesture codes, register indexes, reset values and the config struct.
// No dependencies.
package hegd_pkg;

  // Field widths
  localparam int DIST_W   = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Zone codes
  typedef enum logic [1:0] {
    ZN_EMPTY = 2'd0,
    ZN_NEAR  = 2'd1,
    ZN_FAR   = 2'd2,
    ZN_MID   = 2'd3
  } zone_t;

  // Gesture codes
  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_ENTER = 2'd1,
    GEST_LEAVE = 2'd2
  } gesture_t;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MAX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_EMPTY_MAX = 16'd74;
  localparam logic [CFG_W-1:0] RST_NEAR_MAX  = 16'd135;
  localparam logic [CFG_W-1:0] RST_FAR_MIN   = 16'd180;
  localparam logic [CFG_W-1:0] RST_DWELL     = 16'd120;
  localparam logic [CFG_W-1:0] RST_MEMORY    = 16'd1500;
  localparam logic [CFG_W-1:0] RST_LOCKOUT   = 16'd800;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [CFG_W-1:0] empty_max_mm;
    logic [CFG_W-1:0] near_lim_mm;   // upper bound of the near zone
    logic [CFG_W-1:0] far_lim_mm;    // lower bound of the far zone
    logic [CFG_W-1:0] dwell_ms;
    logic [CFG_W-1:0] memory_ms;
    logic [CFG_W-1:0] lockout_ms;
  } cfg_t;

endpackage

[rtl/hegd_zone.sv]
// Zone classifier: sorts one sample into empty, near, far or middle.
// Depends on hegd_pkg.
module hegd_zone (
  input  logic                         sample_valid,
  input  logic [hegd_pkg::DIST_W-1:0]  distance_mm,
  input  hegd_pkg::cfg_t               cfg,
  output hegd_pkg::zone_t              zone
);

  // Empty test first, then near, then far; overlapping thresholds resolve in that order
  always_comb begin
    if (!sample_valid || distance_mm <= cfg.empty_max_mm) begin
      zone = hegd_pkg::ZN_EMPTY;
    end else if (distance_mm <= cfg.near_lim_mm) begin
      zone = hegd_pkg::ZN_NEAR;
    end else if (distance_mm >= cfg.far_lim_mm) begin
      zone = hegd_pkg::ZN_FAR;
    end else begin
      zone = hegd_pkg::ZN_MID;
    end
  end

endmodule

[rtl/hegd_track.sv]
// Tracking state and gesture decision for one sample per step.
// Depends on hegd_pkg.
module hegd_track (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  hegd_pkg::cfg_t               cfg,
  input  hegd_pkg::zone_t              zone,
  input  logic [hegd_pkg::TIME_W-1:0]  now,
  output hegd_pkg::gesture_t           gesture
);

  hegd_pkg::zone_t             stable_r, stable_nxt;
  hegd_pkg::zone_t             cand_r, cand_nxt;
  logic                        seen_r, seen_nxt;
  logic                        sess_r, sess_nxt;
  logic [hegd_pkg::TIME_W-1:0] hand_time_r, hand_time_nxt;
  logic [hegd_pkg::TIME_W-1:0] cand_time_r, cand_time_nxt;
  logic [hegd_pkg::TIME_W-1:0] lock_end_r, lock_end_nxt;

  logic [hegd_pkg::TIME_W-1:0] hand_upd;
  logic [hegd_pkg::TIME_W-1:0] hand_dt;
  logic [hegd_pkg::TIME_W-1:0] cand_dt;
  logic [hegd_pkg::TIME_W-1:0] lock_new;
  logic                        expired;
  logic                        seen_mid;
  hegd_pkg::zone_t             stable_mid;

  // Time differences wrap at 32 bits
  assign hand_upd = (sess_r && (zone == hegd_pkg::ZN_NEAR || zone == hegd_pkg::ZN_MID))
                    ? now : hand_time_r;
  assign hand_dt  = now - hand_upd;
  assign cand_dt  = now - cand_time_r;
  assign lock_new = now + {{(hegd_pkg::TIME_W-hegd_pkg::CFG_W){1'b0}}, cfg.lockout_ms};
  assign expired  = hand_dt > {{(hegd_pkg::TIME_W-hegd_pkg::CFG_W){1'b0}}, cfg.memory_ms};

  // Hand memory expiry outside a session
  always_comb begin
    seen_mid   = seen_r;
    stable_mid = stable_r;
    if (seen_r && !sess_r && expired) begin
      seen_mid   = 1'b0;
      stable_mid = hegd_pkg::ZN_EMPTY;
    end
  end

  // Next state and gesture
  always_comb begin
    stable_nxt    = stable_mid;
    cand_nxt      = cand_r;
    seen_nxt      = seen_mid;
    sess_nxt      = sess_r;
    hand_time_nxt = hand_upd;
    cand_time_nxt = cand_time_r;
    lock_end_nxt  = lock_end_r;
    gesture       = hegd_pkg::GEST_NONE;
    if (sess_r && expired) begin
      // session timeout
      stable_nxt   = stable_r;
      seen_nxt     = 1'b0;
      sess_nxt     = 1'b0;
      lock_end_nxt = lock_new;
      gesture      = hegd_pkg::GEST_LEAVE;
    end else if ((zone != hegd_pkg::ZN_NEAR && zone != hegd_pkg::ZN_FAR) ||
                 (now < lock_end_r)) begin
      // no hand zone, or locked out
      gesture = hegd_pkg::GEST_NONE;
    end else if (zone != cand_r) begin
      // new candidate zone starts its dwell
      cand_nxt      = zone;
      cand_time_nxt = now;
    end else if (cand_dt >= {{(hegd_pkg::TIME_W-hegd_pkg::CFG_W){1'b0}}, cfg.dwell_ms}) begin
      // candidate has dwelt long enough: it becomes stable
      if (seen_mid) begin
        if (!sess_r && stable_mid == hegd_pkg::ZN_FAR && zone == hegd_pkg::ZN_NEAR) begin
          gesture  = hegd_pkg::GEST_ENTER;
          sess_nxt = 1'b1;
        end else if (sess_r && stable_mid == hegd_pkg::ZN_NEAR &&
                     zone == hegd_pkg::ZN_FAR) begin
          gesture  = hegd_pkg::GEST_LEAVE;
          sess_nxt = 1'b0;
        end
      end
      stable_nxt    = zone;
      seen_nxt      = 1'b1;
      hand_time_nxt = now;
      if (gesture != hegd_pkg::GEST_NONE) begin
        lock_end_nxt = lock_new;
      end
    end
  end

  // State registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= hegd_pkg::ZN_EMPTY;
      cand_r      <= hegd_pkg::ZN_EMPTY;
      seen_r      <= 1'b0;
      sess_r      <= 1'b0;
      hand_time_r <= '0;
      cand_time_r <= '0;
      lock_end_r  <= '0;
    end else if (step_en) begin
      stable_r    <= stable_nxt;
      cand_r      <= cand_nxt;
      seen_r      <= seen_nxt;
      sess_r      <= sess_nxt;
      hand_time_r <= hand_time_nxt;
      cand_time_r <= cand_time_nxt;
      lock_end_r  <= lock_end_nxt;
    end
  end

endmodule

[rtl/hand_enter_leave_gesture_detector.sv]
// Hand enter/leave gesture detector, top level: config registers, input and result registers.
// An accepted input beat passes the input register, then the result register, to out_tdata.
// Throughput: one beat per cycle when out_tready is high; tracking steps once per beat.
// Reset: synchronous, active low rst_n; clears state, handshake flags, config to defaults.
// Depends on hegd_pkg, hegd_zone, hegd_track.
module hand_enter_leave_gesture_detector (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] distance_mm, [47:16] time_ms
  input  logic        in_tuser,   // [0] sample_valid
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] gesture, [7:2] zero
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [hegd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hegd_pkg::CFG_W-1:0]     cfg_data
);

  hegd_pkg::cfg_t              cfg_r;
  logic                        in_vld_r;
  logic                        smp_valid_r;
  logic [hegd_pkg::DIST_W-1:0] dist_r;
  logic [hegd_pkg::TIME_W-1:0] time_r;
  logic                        out_vld_r;
  hegd_pkg::gesture_t          gest_r;
  logic                        advance;
  hegd_pkg::zone_t             zone;
  hegd_pkg::gesture_t          gest;

  // Config registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.empty_max_mm <= hegd_pkg::RST_EMPTY_MAX;
      cfg_r.near_lim_mm  <= hegd_pkg::RST_NEAR_MAX;
      cfg_r.far_lim_mm   <= hegd_pkg::RST_FAR_MIN;
      cfg_r.dwell_ms     <= hegd_pkg::RST_DWELL;
      cfg_r.memory_ms    <= hegd_pkg::RST_MEMORY;
      cfg_r.lockout_ms   <= hegd_pkg::RST_LOCKOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        hegd_pkg::REG_EMPTY_MAX: cfg_r.empty_max_mm <= cfg_data;
        hegd_pkg::REG_NEAR_MAX:  cfg_r.near_lim_mm  <= cfg_data;
        hegd_pkg::REG_FAR_MIN:   cfg_r.far_lim_mm   <= cfg_data;
        hegd_pkg::REG_DWELL:     cfg_r.dwell_ms     <= cfg_data;
        hegd_pkg::REG_MEMORY:    cfg_r.memory_ms    <= cfg_data;
        hegd_pkg::REG_LOCKOUT:   cfg_r.lockout_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input stage moves on when the result register is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_valid_r <= in_tuser;
      dist_r      <= in_tdata[15:0];
      time_r      <= in_tdata[47:16];
    end
  end

  // Classification and tracking
  hegd_zone u_zone (
    .sample_valid (smp_valid_r),
    .distance_mm  (dist_r),
    .cfg          (cfg_r),
    .zone         (zone)
  );

  hegd_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg_r),
    .zone    (zone),
    .now     (time_r),
    .gesture (gest)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gest_r <= gest;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, gest_r};

endmodule

[bench/tb_hand_enter_leave_gesture_detector.sv]
// Self-checking bench for hand_enter_leave_gesture_detector: a queue-fed stream driver,
// a result monitor and an in-bench gesture predictor, run over several register settings.
// Depends on hegd_pkg and the detector RTL.
module tb_hand_enter_leave_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 20;
  // indexes past the register file, writes there must be dropped
  localparam logic [hegd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [hegd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                        sample_ok;
    logic [hegd_pkg::DIST_W-1:0] mm;
    logic [hegd_pkg::TIME_W-1:0] stamp;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;  // [15:0] distance_mm, [47:16] time_ms
  logic in_tuser = 1'b0;       // [0] sample_valid
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;       // [1:0] gesture, [7:2] zero
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hegd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hegd_pkg::CFG_W-1:0] cfg_data = '0;

  hand_enter_leave_gesture_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow registers
  logic [hegd_pkg::CFG_W-1:0] sh_empty_max = hegd_pkg::RST_EMPTY_MAX;
  logic [hegd_pkg::CFG_W-1:0] sh_near_max  = hegd_pkg::RST_NEAR_MAX;
  logic [hegd_pkg::CFG_W-1:0] sh_far_min   = hegd_pkg::RST_FAR_MIN;
  logic [hegd_pkg::CFG_W-1:0] sh_dwell     = hegd_pkg::RST_DWELL;
  logic [hegd_pkg::CFG_W-1:0] sh_memory    = hegd_pkg::RST_MEMORY;
  logic [hegd_pkg::CFG_W-1:0] sh_lockout   = hegd_pkg::RST_LOCKOUT;

  // tracker state of the predictor
  hegd_pkg::zone_t             trk_stable = hegd_pkg::ZN_EMPTY;
  hegd_pkg::zone_t             trk_cand   = hegd_pkg::ZN_EMPTY;
  logic                        trk_hand   = 1'b0;
  logic                        trk_open   = 1'b0;
  logic [hegd_pkg::TIME_W-1:0] trk_hand_ts = '0;
  logic [hegd_pkg::TIME_W-1:0] trk_cand_ts = '0;
  logic [hegd_pkg::TIME_W-1:0] trk_lock_end = '0;

  sample_t            sample_q[$];
  hegd_pkg::gesture_t gesture_q[$];

  int in_gap_max = 0;
  int out_stall_max = 0;
  int tick_max = 60;
  logic [hegd_pkg::TIME_W-1:0] ts_ms = '0;
  int fault_cnt = 0;
  int n_samples = 0;
  int n_settings = 1;
  int n_enter = 0;
  int n_leave = 0;
  int n_timeout = 0;
  int cycle_cnt = 0;

  task automatic flag_fault(input string what);
    if (fault_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    fault_cnt++;
  endtask

  // One sample through the tracker; updates the shadow state.
  function automatic hegd_pkg::gesture_t predict_gesture(
      input logic ok, input logic [hegd_pkg::DIST_W-1:0] d,
      input logic [hegd_pkg::TIME_W-1:0] now);
    hegd_pkg::zone_t z;
    hegd_pkg::gesture_t g;
    logic [hegd_pkg::TIME_W-1:0] since_hand;
    logic [hegd_pkg::TIME_W-1:0] since_cand;
    // empty test first, then near, then far
    if (!ok || d <= sh_empty_max) z = hegd_pkg::ZN_EMPTY;
    else if (d <= sh_near_max) z = hegd_pkg::ZN_NEAR;
    else if (d >= sh_far_min) z = hegd_pkg::ZN_FAR;
    else z = hegd_pkg::ZN_MID;
    g = hegd_pkg::GEST_NONE;
    if (trk_open && (z == hegd_pkg::ZN_NEAR || z == hegd_pkg::ZN_MID)) trk_hand_ts = now;
    since_hand = now - trk_hand_ts;
    // open session with no hand for too long
    if (trk_open && since_hand > {16'd0, sh_memory}) begin
      trk_open = 1'b0;
      trk_hand = 1'b0;
      trk_lock_end = now + {16'd0, sh_lockout};
      n_leave++;
      n_timeout++;
      return hegd_pkg::GEST_LEAVE;
    end
    if (trk_hand && !trk_open && since_hand > {16'd0, sh_memory}) begin
      trk_hand = 1'b0;
      trk_stable = hegd_pkg::ZN_EMPTY;
    end
    if (z != hegd_pkg::ZN_NEAR && z != hegd_pkg::ZN_FAR) return hegd_pkg::GEST_NONE;
    // lockout: plain unsigned compare, no wrap
    if (now < trk_lock_end) return hegd_pkg::GEST_NONE;
    if (z != trk_cand) begin
      trk_cand = z;
      trk_cand_ts = now;
      return hegd_pkg::GEST_NONE;
    end
    since_cand = now - trk_cand_ts;
    if (since_cand < {16'd0, sh_dwell}) return hegd_pkg::GEST_NONE;
    if (trk_hand) begin
      if (!trk_open && trk_stable == hegd_pkg::ZN_FAR && z == hegd_pkg::ZN_NEAR) begin
        g = hegd_pkg::GEST_ENTER;
        trk_open = 1'b1;
        n_enter++;
      end else if (trk_open && trk_stable == hegd_pkg::ZN_NEAR && z == hegd_pkg::ZN_FAR) begin
        g = hegd_pkg::GEST_LEAVE;
        trk_open = 1'b0;
        n_leave++;
      end
    end
    trk_stable = z;
    trk_hand = 1'b1;
    trk_hand_ts = now;
    if (g != hegd_pkg::GEST_NONE) trk_lock_end = now + {16'd0, sh_lockout};
    return g;
  endfunction

  // Input driver: one beat per queued sample, random gap after each beat
  sample_t drv_cur;
  int      drv_gap = 0;
  always @(posedge clk) begin
    logic vld_next;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      drv_gap = 0;
    end else begin
      vld_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        gesture_q.push_back(predict_gesture(drv_cur.sample_ok, drv_cur.mm, drv_cur.stamp));
        n_samples++;
        vld_next = 1'b0;
        drv_gap = $urandom_range(in_gap_max, 0);
      end
      if (!vld_next) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (sample_q.size() > 0) begin
          drv_cur = sample_q.pop_front();
          in_tdata <= {drv_cur.stamp, drv_cur.mm};
          in_tuser <= drv_cur.sample_ok;
          vld_next = 1'b1;
        end
      end
      in_tvalid <= vld_next;
    end
  end

  // Result monitor: compare each beat with the oldest expected gesture
  int mon_stall = 0;
  always @(posedge clk) begin
    hegd_pkg::gesture_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mon_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (gesture_q.size() == 0) begin
          flag_fault($sformatf("result beat 0x%02h with nothing expected", out_tdata));
        end else begin
          want = gesture_q.pop_front();
          if (out_tdata != {6'd0, want})
            flag_fault($sformatf("gesture got 0x%02h want %s", out_tdata, want.name()));
        end
        mon_stall = $urandom_range(out_stall_max, 0);
      end else if (mon_stall > 0) begin
        mon_stall--;
      end
      out_tready <= (mon_stall == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[hand_enter_leave_gesture_detector] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [hegd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hegd_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hegd_pkg::REG_EMPTY_MAX: sh_empty_max = val;
      hegd_pkg::REG_NEAR_MAX:  sh_near_max  = val;
      hegd_pkg::REG_FAR_MIN:   sh_far_min   = val;
      hegd_pkg::REG_DWELL:     sh_dwell     = val;
      hegd_pkg::REG_MEMORY:    sh_memory    = val;
      hegd_pkg::REG_LOCKOUT:   sh_lockout   = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int e, input int n, input int f, input int dw, input int m,
                          input int lk);
    write_reg(hegd_pkg::REG_EMPTY_MAX, e[hegd_pkg::CFG_W-1:0]);
    write_reg(hegd_pkg::REG_NEAR_MAX,  n[hegd_pkg::CFG_W-1:0]);
    write_reg(hegd_pkg::REG_FAR_MIN,   f[hegd_pkg::CFG_W-1:0]);
    write_reg(hegd_pkg::REG_DWELL,     dw[hegd_pkg::CFG_W-1:0]);
    write_reg(hegd_pkg::REG_MEMORY,    m[hegd_pkg::CFG_W-1:0]);
    write_reg(hegd_pkg::REG_LOCKOUT,   lk[hegd_pkg::CFG_W-1:0]);
    // stray write to a spare index, must leave everything alone
    write_reg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO,
              hegd_pkg::CFG_W'($urandom));
    // time step scaled so segments outlast the dwell and, often, the lockout
    tick_max = (int'(sh_dwell) + int'(sh_lockout) / 4) / 2 + 8;
    n_settings++;
  endtask

  task automatic push_sample(input logic ok, input logic [hegd_pkg::DIST_W-1:0] d,
                             input logic [hegd_pkg::TIME_W-1:0] step);
    ts_ms += step;
    sample_q.push_back('{sample_ok: ok, mm: d, stamp: ts_ms});
  endtask

  // distance within the wanted zone's own threshold bounds, any value if none fits
  function automatic logic [hegd_pkg::DIST_W-1:0] pick_dist(input hegd_pkg::zone_t z);
    int lo, hi;
    case (z)
      hegd_pkg::ZN_EMPTY: begin lo = 0; hi = int'(sh_empty_max); end
      hegd_pkg::ZN_NEAR:  begin lo = int'(sh_empty_max) + 1; hi = int'(sh_near_max); end
      hegd_pkg::ZN_FAR:   begin lo = int'(sh_far_min); hi = 65535; end
      default:            begin lo = int'(sh_near_max) + 1; hi = int'(sh_far_min) - 1; end
    endcase
    if (lo > hi || lo > 65535) return hegd_pkg::DIST_W'($urandom);
    return hegd_pkg::DIST_W'($urandom_range(hi, lo));
  endfunction

  // Mostly far/near hand segments with noise, plus quiet spells, jumps and junk
  task automatic queue_random(input int n);
    int left, seg_len, r, k;
    hegd_pkg::zone_t seg_zone, last_zone;
    left = n;
    last_zone = hegd_pkg::ZN_FAR;
    while (left > 0) begin
      r = $urandom_range(99, 0);
      if (r < 72) begin
        if ($urandom_range(9, 0) < 8)
          seg_zone = (last_zone == hegd_pkg::ZN_NEAR) ? hegd_pkg::ZN_FAR : hegd_pkg::ZN_NEAR;
        else seg_zone = hegd_pkg::zone_t'($urandom_range(3, 0));
        last_zone = seg_zone;
        seg_len = $urandom_range(10, 2);
        for (k = 0; k < seg_len && left > 0; k++) begin
          if ($urandom_range(11, 0) == 0)
            push_sample(1'($urandom_range(1, 0)), hegd_pkg::DIST_W'($urandom),
                        $urandom_range(tick_max, 0));
          else
            push_sample(1'b1, pick_dist(seg_zone), $urandom_range(tick_max, 0));
          left--;
        end
      end else if (r < 82) begin
        // silence right around the memory limit
        push_sample(1'($urandom_range(1, 0)),
                    pick_dist($urandom_range(1, 0) ? hegd_pkg::ZN_FAR : hegd_pkg::ZN_EMPTY),
                    {16'd0, sh_memory} + $urandom_range(2, 0));
        left--;
      end else if (r < 86) begin
        // timestamp jumps anywhere, backwards included
        ts_ms = $urandom;
        push_sample(1'b1, pick_dist(hegd_pkg::zone_t'($urandom_range(3, 0))), 0);
        left--;
      end else begin
        for (k = $urandom_range(4, 1); k > 0 && left > 0; k--) begin
          push_sample(1'($urandom_range(1, 0)), hegd_pkg::DIST_W'($urandom), $urandom);
          left--;
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (sample_q.size() != 0 || in_tvalid || gesture_q.size() != 0);
  endtask

  // Half the items, full drain with the sender held off, then the rest
  task automatic run_phase(input int n, input int gap, input int stall,
                           input logic [hegd_pkg::TIME_W-1:0] start_ts);
    in_gap_max = gap;
    out_stall_max = stall;
    ts_ms = start_ts;
    queue_random(n / 2);
    wait_idle();
    queue_random(n - n / 2);
    wait_idle();
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples at reset settings
    in_gap_max = 2;
    out_stall_max = 2;
    ts_ms = '0;
    push_sample(1'b0, 16'hFFFF, 10);  // invalid reading counts as empty
    push_sample(1'b1, 16'd0, 5);
    push_sample(1'b1, 16'd74, 5);     // empty edge
    push_sample(1'b1, 16'd75, 5);     // near edge
    push_sample(1'b1, 16'd135, 5);
    push_sample(1'b1, 16'd136, 5);    // middle
    push_sample(1'b1, 16'd179, 5);
    push_sample(1'b1, 16'd180, 5);    // far edge
    push_sample(1'b1, 16'hFFFF, 5);
    push_sample(1'b1, 16'd200, 120);  // far becomes stable
    push_sample(1'b1, 16'd100, 50);
    push_sample(1'b1, 16'd100, 119);  // one short of the dwell
    push_sample(1'b1, 16'd100, 1);    // enter
    push_sample(1'b1, 16'd120, 400);
    push_sample(1'b1, 16'd300, 100);  // inside lockout
    push_sample(1'b1, 16'd300, 300);  // lockout just over
    push_sample(1'b1, 16'd300, 120);  // leave
    push_sample(1'b1, 16'd300, 800);
    push_sample(1'b1, 16'd90, 10);
    push_sample(1'b1, 16'd90, 120);   // enter again
    push_sample(1'b1, 16'd0, 1500);   // exactly at the memory limit
    push_sample(1'b0, 16'd0, 1);      // one past: leave by timeout
    ts_ms = 32'hFFFF_FFC0;
    push_sample(1'b1, 16'd400, 0);
    push_sample(1'b1, 16'd400, 120);  // time wraps, lockout compare does not
    push_sample(1'b1, 16'd100, 5000);
    wait_idle();

    // Random phases over a spread of settings
    run_phase(350, 5, 5, $urandom);
    set_regs(0, 100, 101, 0, 0, 0);
    run_phase(250, 0, 0, $urandom);
    set_regs(10, 65534, 65535, 65535, 65535, 65535);
    run_phase(150, 3, 1, 32'hFFFF_F000);
    set_regs(50, 500, 400, 30, 200, 100);            // near and far overlap
    run_phase(250, 5, 0, $urandom);
    set_regs(300, 200, 100, 40, 300, 0);             // thresholds out of order
    run_phase(100, 0, 5, $urandom);
    set_regs(65535, 65535, 65535, 0, 0, 0);          // everything empty
    run_phase(50, 1, 1, $urandom);
    repeat (2) begin
      set_regs($urandom_range(200, 0), $urandom_range(500, 201), $urandom_range(900, 300),
               $urandom_range(400, 0), $urandom_range(3000, 0), $urandom_range(2000, 0));
      run_phase(200, $urandom_range(5, 0), $urandom_range(5, 0), $urandom);
    end
    set_regs(int'(hegd_pkg::RST_EMPTY_MAX), int'(hegd_pkg::RST_NEAR_MAX),
             int'(hegd_pkg::RST_FAR_MIN), int'(hegd_pkg::RST_DWELL),
             int'(hegd_pkg::RST_MEMORY), int'(hegd_pkg::RST_LOCKOUT));

    repeat (8) @(posedge clk);
    if (gesture_q.size() != 0)
      flag_fault($sformatf("%0d expected gestures never came out", gesture_q.size()));
    $display("covered %0d samples under %0d register settings", n_samples, n_settings);
    $display("predicted %0d enter and %0d leave gestures, %0d leaves by timeout",
             n_enter, n_leave, n_timeout);
    if (fault_cnt == 0) begin
      $display("[hand_enter_leave_gesture_detector] OK");
    end else begin
      $display("[hand_enter_leave_gesture_detector] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hegd_pkg.sv
rtl/hegd_zone.sv
rtl/hegd_track.sv
rtl/hand_enter_leave_gesture_detector.sv
bench/tb_hand_enter_leave_gesture_detector.sv
